// ===== hdl/tmt64_pkg.sv =====
// Shared constants, types and functions for the TinyMT64-style generator.
package tmt64_pkg;

  localparam logic [63:0] MIX_A    = 64'h0000_0000_FA05_1F40;
  localparam logic [63:0] MIX_B    = 64'h0000_0000_FFD0_FFF4;
  localparam logic [63:0] TEMPER_K = 64'h58D0_2FFE_FFBF_FFBC;
  localparam logic [63:0] LOW63    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned FOLD_SH  = 62;
  localparam int unsigned ROUNDS   = 8;
  localparam int unsigned XW       = 64;  // data path width
  localparam int unsigned CW       = 6;   // step counter width, XW steps
  localparam int unsigned DW       = 33;  // divisor width, span up to 2^32

  // Request selector codes
  localparam logic [1:0] FN_RESEED = 2'd0;
  localparam logic [1:0] FN_WORD   = 2'd1;
  localparam logic [1:0] FN_RANGED = 2'd2;

  // Operation of the shared shift/add unit
  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_REM = 2'b10
  } tmt_op_t;

  // Control from the sequencer to the shared unit
  typedef struct packed {
    logic       start;
    tmt_op_t    op;
    logic [3:0] init;   // accumulator start value for multiply
  } tmt_req_t;

  // Result of one generator advance
  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] word;
  } tmt_adv_t;

  // Fold of the top bits used by the seeding rounds
  function automatic logic [63:0] tmt_fold(input logic [63:0] v);
    return v ^ (v >> FOLD_SH);
  endfunction

  // One state advance plus tempering
  function automatic tmt_adv_t tmt_advance(input logic [63:0] s1, input logic [63:0] s2);
    logic [63:0] x;
    logic [63:0] y;
    tmt_adv_t    r;
    x = (s1 & LOW63) ^ s2;
    x = x ^ (x << 12);
    x = x ^ (x >> 32);
    x = x ^ (x << 32);
    x = x ^ (x << 11);
    r.first  = s2 ^ (x[0] ? MIX_A : 64'd0);
    r.second = x ^ (x[0] ? (MIX_B << 32) : 64'd0);
    y = (r.first + r.second) ^ (r.first >> 8);
    r.word = y ^ (y[0] ? TEMPER_K : 64'd0);
    return r;
  endfunction

  // Seeding evaluated at elaboration, gives the state after reset
  function automatic logic [127:0] tmt_reseed(input logic [63:0] s);
    logic [63:0] p;
    logic [63:0] q;
    p = s ^ (MIX_A << 32);
    q = MIX_B ^ TEMPER_K;
    for (int k = 1; k <= ROUNDS; k++) begin
      if ((k % 2) == 1) begin
        q = q ^ (64'(k) + TEMPER_K * tmt_fold(p));
      end else begin
        p = p ^ (64'(k) + TEMPER_K * tmt_fold(q));
      end
    end
    return {p, q};
  endfunction

  localparam logic [127:0] RST_STATE  = tmt_reseed(64'd0);
  localparam logic [63:0]  RST_FIRST  = RST_STATE[127:64];
  localparam logic [63:0]  RST_SECOND = RST_STATE[63:0];

endpackage

// ===== hdl/tmt64_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface tmt64_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [63:0]        seed;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, func, seed, range_low, range_high, input ready);
  modport sink   (input valid, func, seed, range_low, range_high, output ready);
endinterface

interface tmt64_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        word;
  logic signed [31:0] ranged_value;

  modport source (output valid, word, ranged_value, input ready);
  modport sink   (input valid, word, ranged_value, output ready);
endinterface

// ===== hdl/tmt64_iter_unit.sv =====
// Shared bit-serial unit: 64-bit multiply by the tempering constant, or 64/33 remainder.
module tmt64_iter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  tmt64_pkg::tmt_req_t req,
  input  logic [63:0]         opa,
  input  logic [32:0]         div,
  output logic                done,
  output logic [63:0]         result
);
  import tmt64_pkg::*;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  tmt_op_t       op_r;
  logic [XW-1:0] acc_r, acc_nxt;
  logic [XW-1:0] sh_r, sh_nxt;
  logic [XW-1:0] mc_r, mc_nxt;
  logic [DW-1:0] div_r;
  logic [XW-1:0] add_a, add_b, rem_sh;
  logic          add_ci;
  logic [XW:0]   sum;

  // Operand selection for the single adder
  always_comb begin
    rem_sh = {acc_r[XW-2:0], sh_r[XW-1]};
    if (op_r == OP_MUL) begin
      add_a  = acc_r;
      add_b  = sh_r[0] ? mc_r : '0;
      add_ci = 1'b0;
    end else begin
      add_a  = rem_sh;
      add_b  = ~{{(XW-DW){1'b0}}, div_r};
      add_ci = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{XW{1'b0}}, add_ci};
  end

  // Step update: one multiplier bit or one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mc_nxt   = mc_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(XW - 1)) begin
        busy_nxt = 1'b0;
      end
      if (op_r == OP_MUL) begin
        acc_nxt = sum[XW-1:0];
        sh_nxt  = sh_r >> 1;
        mc_nxt  = mc_r << 1;
      end else begin
        // carry out means no borrow: shifted remainder >= divisor
        acc_nxt = sum[XW] ? sum[XW-1:0] : rem_sh;
        sh_nxt  = sh_r << 1;
      end
    end
  end

  assign done   = busy_r && (cnt_r == CW'(XW - 1));
  assign result = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= (req.op == OP_MUL) ? {{(XW-4){1'b0}}, req.init} : '0;
      sh_r  <= opa;
      mc_r  <= TEMPER_K;
      div_r <= div;
    end else begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
      mc_r  <= mc_nxt;
    end
  end

endmodule

// ===== hdl/tinymt64_generator_core.sv =====
// Top level of the TinyMT64-style generator: request sequencer, state and result register.
//
// Usage: requests arrive on in_ch (valid/ready) with func, seed and a signed
// range; exactly one result transaction per request leaves on out_ch.
// func 0 reseeds (result zero), func 1 returns a tempered 64-bit word,
// func 2 returns range_low + (draw mod span), or range_low with no state
// change when range_low >= range_high; func 3 returns zeros.
// The block takes one request at a time: in_ch.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so a
// new request can be taken while that result still waits.
// The path from acceptance to out_ch.valid depends on the case: func 3 and
// empty ranges go straight to the finish state, func 1 passes one step state,
// a ranged draw adds a remainder, and a reseed runs one multiply per round.
// Multiply and remainder run in the shared shift/add unit, one bit per cycle,
// plus one issue state per round. in_ch.ready returns in the cycle after the
// result is loaded into the output register.
// If out_ch.ready stays low, the next result waits in the sequencer until
// the output register frees up; nothing is dropped.
// Reset (synchronous, active low) loads the state a seed of zero gives and
// empties the output register; no clearing pass is needed.
module tinymt64_generator_core (
  input logic          clk,
  input logic          rst_n,
  tmt64_in_if.sink     in_ch,
  tmt64_out_if.source  out_ch
);
  import tmt64_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RSTART = 6'b000010,
    S_RWAIT  = 6'b000100,
    S_STEP   = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [63:0]        first_r, first_nxt;
  logic [63:0]        second_r, second_nxt;
  logic [3:0]         round_r, round_nxt;
  logic [1:0]         func_r;
  logic signed [31:0] lo_r;
  logic [32:0]        span_r;
  logic [63:0]        res_word_r, res_word_nxt;
  logic [31:0]        res_rng_r, res_rng_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_word_r;
  logic [31:0]        out_rng_r;
  logic               load_out;
  logic               in_acc;
  logic               range_empty;
  logic [32:0]        span_in;
  tmt_req_t           req;
  logic [63:0]        iu_opa;
  logic               iu_done;
  logic [63:0]        iu_result;
  tmt_adv_t           adv;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign range_empty = (in_ch.range_low >= in_ch.range_high);
  assign span_in     = {in_ch.range_high[31], in_ch.range_high}
                     - {in_ch.range_low[31], in_ch.range_low} + 33'd1;
  assign adv         = tmt_advance(first_r, second_r);
  assign load_out    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Shared unit requests: seeding multiply or remainder of the draw
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    req.init  = round_r;
    iu_opa    = round_r[0] ? tmt_fold(first_r) : tmt_fold(second_r);
    if (state_r == S_RSTART) begin
      req.start = 1'b1;
    end else if (state_r == S_STEP && func_r == FN_RANGED) begin
      req.start = 1'b1;
      req.op    = OP_REM;
      req.init  = '0;
      iu_opa    = adv.word;
    end
  end

  tmt64_iter_unit u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (iu_opa),
    .div    (span_r),
    .done   (iu_done),
    .result (iu_result)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    round_nxt    = round_r;
    res_word_nxt = res_word_r;
    res_rng_nxt  = res_rng_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_word_nxt = '0;
          res_rng_nxt  = '0;
          unique case (in_ch.func)
            FN_RESEED: begin
              first_nxt  = in_ch.seed ^ (MIX_A << 32);
              second_nxt = MIX_B ^ TEMPER_K;
              round_nxt  = 4'd1;
              state_nxt  = S_RSTART;
            end
            FN_WORD: state_nxt = S_STEP;
            FN_RANGED: begin
              if (range_empty) begin
                res_rng_nxt = in_ch.range_low;
                state_nxt   = S_FIN;
              end else begin
                state_nxt = S_STEP;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_RSTART: state_nxt = S_RWAIT;
      S_RWAIT: begin
        if (iu_done) begin
          // odd rounds fold into the second word, even rounds into the first
          if (round_r[0]) begin
            second_nxt = second_r ^ iu_result;
          end else begin
            first_nxt = first_r ^ iu_result;
          end
          round_nxt = round_r + 4'd1;
          state_nxt = (round_r == 4'(ROUNDS)) ? S_FIN : S_RSTART;
        end
      end
      S_STEP: begin
        first_nxt  = adv.first;
        second_nxt = adv.second;
        if (func_r == FN_WORD) begin
          res_word_nxt = adv.word;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (iu_done) begin
          res_rng_nxt = lo_r + iu_result[31:0];
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= RST_FIRST;
      second_r    <= RST_SECOND;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      lo_r   <= in_ch.range_low;
      span_r <= span_in;
    end
    res_word_r <= res_word_nxt;
    res_rng_r  <= res_rng_nxt;
    if (load_out) begin
      out_word_r <= res_word_r;
      out_rng_r  <= res_rng_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.word         = out_word_r;
  assign out_ch.ranged_value = out_rng_r;

endmodule
